>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk and is
// switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define CIA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CIA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/cia_pkg.sv
`timescale 1ns / 1ps

package cia_pkg;

  localparam int S_DATA_W    = 136;
  localparam int M_DATA_W    = 72;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] ACT_ADD = 4'd0;
  localparam logic [3:0] ACT_MUL = 4'd1;
  localparam logic [3:0] ACT_DIV = 4'd2;
  localparam logic [3:0] ACT_MOD = 4'd3;
  localparam logic [3:0] ACT_LT  = 4'd4;
  localparam logic [3:0] ACT_LE  = 4'd5;
  localparam logic [3:0] ACT_EQ  = 4'd6;
  localparam logic [3:0] ACT_AND = 4'd7;
  localparam logic [3:0] ACT_OR  = 4'd8;
  localparam logic [3:0] ACT_XOR = 4'd9;
  localparam logic [3:0] ACT_SHL = 4'd10;
  localparam logic [3:0] ACT_SHR = 4'd11;
  localparam logic [3:0] ACT_NEG = 4'd12;
  localparam logic [3:0] ACT_NOT = 4'd13;

  localparam logic [2:0] FAULT_NONE     = 3'd0;
  localparam logic [2:0] FAULT_OVERFLOW = 3'd1;
  localparam logic [2:0] FAULT_DIV_ZERO = 3'd2;
  localparam logic [2:0] FAULT_NOT_REPR = 3'd3;
  localparam logic [2:0] FAULT_BAD_SHAMT = 3'd4;
  localparam logic [2:0] FAULT_BAD_SHL  = 3'd5;

  typedef enum logic [1:0] {
    CLS_DONE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    cls_t        cls;
    logic        is_mod;
    logic [1:0]  kind;
    logic        neg;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] value;
    logic [2:0]  fault;
  } entry_t;

  // Kind bit 1 set means 64 bits wide, kind bit 0 set means unsigned.
  function automatic logic [63:0] narrow(logic [1:0] k, logic [63:0] v);
    logic [63:0] r;
    r = v;
    if (!k[1]) begin
      r = k[0] ? {32'd0, v[31:0]} : {{32{v[31]}}, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [63:0] max_pos(logic [1:0] k);
    return k[1] ? 64'h7fff_ffff_ffff_ffff : 64'h0000_0000_7fff_ffff;
  endfunction

  function automatic logic [63:0] min_val(logic [1:0] k);
    return k[1] ? 64'h8000_0000_0000_0000 : 64'hffff_ffff_8000_0000;
  endfunction

endpackage

>>> hw/rtl/checked_integer_alu.sv
`timescale 1ns / 1ps
// Checked integer ALU for the C kinds i32, u32, i64 and u64.
// Requests arrive on the s_ channel (tvalid/tready/tdata/tuser) and results
// leave on the m_ channel, one result per request, in request order.
// A request carries an action and two 64-bit operands in tdata and the kind
// in tuser; a result carries the narrowed value and a fault code (zero value
// on any fault).
// The front classifies each request and resolves every action except
// multiply and an unfaulted divide/remainder in the cycle it is accepted,
// then writes it into a short queue. The back drains the queue into an
// output register. A simple result passes through the queue and the output
// register; a multiply takes four steps of one shared 32x32 multiplier,
// divide and remainder one quotient bit per cycle. Simple actions sustain
// one request per cycle while results are taken; a multiply or divide holds
// the back for its whole length, and requests behind it wait in the queue.
// A stalled receiver holds the output register; the queue keeps accepting
// until it is full, then s_tready drops.
// Reset empties the queue and the output register; no clearing pass follows.
module checked_integer_alu #(
  parameter int QUEUE_DEPTH = cia_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // action[3:0], operand_a[67:4], operand_b[131:68], zero pad
  input  logic [cia_pkg::S_DATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // value[63:0], fault[66:64], zero pad
  output logic [cia_pkg::M_DATA_W-1:0]  m_tdata
);
  import cia_pkg::*;

  entry_t push_entry, head;
  logic   push, full, pop, head_valid;

  cia_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .full     (full),
    .push     (push),
    .entry    (push_entry)
  );

  cia_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cia_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

>>> hw/rtl/cia_front.sv
`timescale 1ns / 1ps

module cia_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // action[3:0], operand_a[67:4], operand_b[131:68], zero pad
  input  logic [cia_pkg::S_DATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]                    s_tuser,
  input  logic                          full,
  output logic                          push,
  output cia_pkg::entry_t               entry
);
  import cia_pkg::*;

  logic [3:0]  action;
  logic [1:0]  kind;
  logic [63:0] na, nb, sum, r, shr_val, shl_val, shl_rest;
  logic        sgn, wide, an, bn, lt, eq, bad_shamt;
  logic [5:0]  shamt, top_bit;
  logic [2:0]  f;
  cls_t        cls;

  assign action = s_tdata[3:0];
  assign kind   = s_tuser;
  assign na     = narrow(kind, s_tdata[67:4]);
  assign nb     = narrow(kind, s_tdata[131:68]);
  assign sgn    = !kind[0];
  assign wide   = kind[1];
  assign an     = na[63];
  assign bn     = nb[63];
  assign sum    = na + nb;
  assign eq     = (na == nb);
  assign lt     = sgn ? ($signed(na) < $signed(nb)) : (na < nb);
  assign shamt  = nb[5:0];
  assign bad_shamt = (|nb[63:6]) || (!wide && nb[5]);
  assign shr_val = na >> shamt;
  assign shl_val = na << shamt;
  // Anything at or above the bit that would reach the sign position overflows.
  assign top_bit  = (wide ? 6'd63 : 6'd31) - shamt;
  assign shl_rest = na >> top_bit;

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  always_comb begin
    r   = 64'd0;
    f   = FAULT_NONE;
    cls = CLS_DONE;
    case (action)
      ACT_ADD: begin
        r = sum;
        if (sgn) begin
          if (wide) begin
            if (((na ^ sum) & (nb ^ sum)) >> 63 != 64'd0) f = FAULT_OVERFLOW;
          end else if (!((&sum[63:31]) || !(|sum[63:31]))) begin
            f = FAULT_OVERFLOW;
          end
        end
      end
      ACT_MUL: cls = CLS_MUL;
      ACT_DIV, ACT_MOD: begin
        if (nb == 64'd0) f = FAULT_DIV_ZERO;
        else if (sgn && na == min_val(kind) && nb == '1) f = FAULT_NOT_REPR;
        else cls = CLS_DIV;
      end
      ACT_LT:  r = {63'd0, lt};
      ACT_LE:  r = {63'd0, lt || eq};
      ACT_EQ:  r = {63'd0, eq};
      ACT_AND: r = na & nb;
      ACT_OR:  r = na | nb;
      ACT_XOR: r = na ^ nb;
      ACT_SHL: begin
        if (bad_shamt) f = FAULT_BAD_SHAMT;
        else if (sgn && (an || shl_rest != 64'd0)) f = FAULT_BAD_SHL;
        else r = shl_val;
      end
      ACT_SHR: begin
        if (bad_shamt) f = FAULT_BAD_SHAMT;
        else r = shr_val;
      end
      ACT_NEG: r = 64'd0 - na;
      ACT_NOT: r = ~na;
      default: r = 64'd0;
    endcase
  end

  always_comb begin
    entry.cls    = cls;
    entry.is_mod = (action == ACT_MOD);
    entry.kind   = kind;
    entry.neg    = sgn && ((action == ACT_MOD) ? an : (an ^ bn));
    entry.mag_a  = (sgn && an) ? (64'd0 - na) : na;
    entry.mag_b  = (sgn && bn) ? (64'd0 - nb) : nb;
    entry.fault  = f;
    if (f != FAULT_NONE) entry.value = 64'd0;
    else if (action == ACT_LT || action == ACT_LE || action == ACT_EQ) entry.value = r;
    else entry.value = narrow(kind, r);
  end

endmodule

>>> hw/rtl/cia_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cia_queue #(
  parameter int DEPTH = cia_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cia_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cia_pkg::entry_t head
);
  import cia_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [IW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `CIA_ASSERT(a_count_range, count <= CW'(DEPTH), "queue count above depth")
  `CIA_ASSERT_IMP(a_pop_nonempty, pop, count != '0, "pop from empty queue")
  `CIA_ASSERT_IMP(a_push_room, push, count != CW'(DEPTH), "push into full queue")

endmodule

>>> hw/rtl/cia_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cia_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  cia_pkg::entry_t               head,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // value[63:0], fault[66:64], zero pad
  output logic [cia_pkg::M_DATA_W-1:0]  m_tdata
);
  import cia_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t       state, state_next;
  entry_t       cur;
  logic [127:0] acc;
  logic [63:0]  rem, quo, value;
  logic [5:0]   cnt;
  logic [2:0]   fault;
  logic         slot_free, sgn;
  logic [31:0]  xi, yj;
  logic [63:0]  pp;
  logic [127:0] pp_ext;
  logic [64:0]  trial, diff;
  logic [63:0]  lo, limit, raw, fin_val;
  logic         mul_ovf;
  logic [2:0]   fin_fault;

  assign slot_free = !m_tvalid || m_tready;
  assign sgn       = !cur.kind[0];

  // One 32x32 partial product per cycle, from the low and high halves of each magnitude.
  assign xi = cnt[1] ? cur.mag_a[63:32] : cur.mag_a[31:0];
  assign yj = cnt[0] ? cur.mag_b[63:32] : cur.mag_b[31:0];
  assign pp = xi * yj;
  always_comb begin
    case (cnt[1:0])
      2'd0:    pp_ext = {64'd0, pp};
      2'd3:    pp_ext = {pp, 64'd0};
      default: pp_ext = {32'd0, pp, 32'd0};
    endcase
  end

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, quo[63]};
  assign diff  = trial - {1'b0, cur.mag_b};

  assign lo      = acc[63:0];
  assign limit   = max_pos(cur.kind) + {63'd0, cur.neg};
  assign mul_ovf = sgn && ((|acc[127:64]) || lo > limit);

  always_comb begin
    if (cur.cls == CLS_MUL) begin
      raw       = cur.neg ? (64'd0 - lo) : lo;
      fin_fault = mul_ovf ? FAULT_OVERFLOW : FAULT_NONE;
    end else begin
      raw       = cur.is_mod ? rem : quo;
      raw       = cur.neg ? (64'd0 - raw) : raw;
      fin_fault = FAULT_NONE;
    end
    fin_val = (fin_fault != FAULT_NONE) ? 64'd0 : narrow(cur.kind, raw);
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (head_valid) begin
          if (head.cls == CLS_DONE) begin
            pop = slot_free;
          end else begin
            pop        = 1'b1;
            state_next = (head.cls == CLS_MUL) ? S_MUL : S_DIV;
          end
        end
      end
      S_MUL:  if (cnt[1:0] == 2'd3) state_next = S_DONE;
      S_DIV:  if (cnt == 6'd63) state_next = S_DONE;
      S_DONE: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop && head.cls != CLS_DONE) begin
      cur <= head;
      acc <= '0;
      rem <= '0;
      quo <= head.mag_a;
      cnt <= '0;
    end else if (state == S_MUL) begin
      acc <= acc + pp_ext;
      cnt <= cnt + 1'b1;
    end else if (state == S_DIV) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_IDLE && pop && head.cls == CLS_DONE) begin
      m_tvalid <= 1'b1;
    end else if (state == S_DONE && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop && head.cls == CLS_DONE) begin
      value <= head.value;
      fault <= head.fault;
    end else if (state == S_DONE && slot_free) begin
      value <= fin_val;
      fault <= fin_fault;
    end
  end

  assign m_tdata = {5'd0, fault, value};

  `CIA_ASSERT_IMP(a_no_pop_busy, state != S_IDLE, !pop, "queue popped while unit busy")
  `CIA_ASSERT_IMP(a_fault_zero, m_tvalid && fault != FAULT_NONE, value == 64'd0,
                  "faulted result carries a value")
  `CIA_ASSERT_NXT(a_mul_len, state == S_MUL && cnt[1:0] == 2'd3, state == S_DONE,
                  "multiply did not finish after four steps")

endmodule

>>> tb/alu_result_checker.sv
`timescale 1ns / 1ps

module alu_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [cia_pkg::S_DATA_W-1:0] s_tdata,
  input  logic [1:0]                   s_tuser,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [cia_pkg::M_DATA_W-1:0] m_tdata,
  output int                           fail_count,
  output int                           pending
);
  import cia_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  fault;
  } alu_result_t;

  alu_result_t expected_q[$];

  function automatic logic [63:0] fit_kind(logic [1:0] k, logic [63:0] v);
    if (k[1]) return v;
    if (k[0]) return {32'd0, v[31:0]};
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic alu_result_t compute_alu(logic [3:0] act, logic [1:0] k,
                                              logic [63:0] ra, logic [63:0] rb);
    logic [63:0]  a, b, r, maxpos, minval, ma, mb;
    logic [127:0] prod;
    logic [2:0]   f;
    logic         sgn, neg, lt;
    int           width;
    alu_result_t  res;
    a = fit_kind(k, ra);
    b = fit_kind(k, rb);
    sgn = !k[0];
    width = k[1] ? 64 : 32;
    maxpos = k[1] ? 64'h7fff_ffff_ffff_ffff : 64'h7fff_ffff;
    minval = k[1] ? 64'h8000_0000_0000_0000 : 64'hffff_ffff_8000_0000;
    r = '0;
    f = FAULT_NONE;
    case (act)
      ACT_ADD: begin
        r = a + b;
        if (sgn) begin
          if (k[1]) begin
            if (((a ^ r) & (b ^ r)) >> 63) f = FAULT_OVERFLOW;
          end else if (fit_kind(k, r) != r) begin
            f = FAULT_OVERFLOW;
          end
        end
      end
      ACT_MUL: begin
        if (!sgn) begin
          r = a * b;
        end else begin
          ma = abs64(a);
          mb = abs64(b);
          prod = ma * mb;
          neg = a[63] != b[63];
          if (prod[127:64] != 0 || prod[63:0] > (neg ? maxpos + 1 : maxpos))
            f = FAULT_OVERFLOW;
          r = neg ? -prod[63:0] : prod[63:0];
        end
      end
      ACT_DIV, ACT_MOD: begin
        if (b == 0) begin
          f = FAULT_DIV_ZERO;
        end else if (!sgn) begin
          r = (act == ACT_DIV) ? a / b : a % b;
        end else if (a == minval && b == '1) begin
          f = FAULT_NOT_REPR;
        end else begin
          ma = abs64(a);
          mb = abs64(b);
          if (act == ACT_DIV) r = (a[63] != b[63]) ? -(ma / mb) : ma / mb;
          else r = a[63] ? -(ma % mb) : ma % mb;
        end
      end
      ACT_LT, ACT_LE: begin
        lt = sgn ? ($signed(a) < $signed(b)) : (a < b);
        r = (act == ACT_LT) ? 64'(lt) : 64'(lt || a == b);
      end
      ACT_EQ:  r = 64'(a == b);
      ACT_AND: r = a & b;
      ACT_OR:  r = a | b;
      ACT_XOR: r = a ^ b;
      ACT_SHL, ACT_SHR: begin
        if (b[63] || b >= width) f = FAULT_BAD_SHAMT;
        else if (act == ACT_SHR) r = a >> b;
        else if (sgn && (a[63] || a > (maxpos >> b))) f = FAULT_BAD_SHL;
        else r = a << b;
      end
      ACT_NEG: r = -a;
      ACT_NOT: r = ~a;
      default: r = '0;
    endcase
    if (f != FAULT_NONE) r = '0;
    else if (act < ACT_LT || act > ACT_EQ) r = fit_kind(k, r);
    res.value = r;
    res.fault = f;
    return res;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_q.push_back(compute_alu(s_tdata[3:0], s_tuser,
                                         s_tdata[67:4], s_tdata[131:68]));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result value=%h fault=%0d", $time,
                   m_tdata[63:0], m_tdata[66:64]);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.value !== m_tdata[63:0] || want.fault !== m_tdata[66:64]) begin
            $display("%0t: mismatch expected value=%h fault=%0d actual value=%h fault=%0d",
                     $time, want.value, want.fault, m_tdata[63:0], m_tdata[66:64]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

>>> tb/tb_checked_integer_alu.sv
`timescale 1ns / 1ps

module tb_checked_integer_alu;
  import cia_pkg::*;

  localparam int RANDOM_REQUESTS = 1600;
  localparam int CYCLE_LIMIT     = 800000;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready, m_tvalid, m_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic [1:0]            s_tuser;
  logic [M_DATA_W-1:0]   m_tdata;
  int                    fail_count, pending;
  int                    cycles = 0;
  logic                  calm, hold_off;

  checked_integer_alu u_dut (.*);

  alu_result_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, none while calm, a long hold-off on request.
  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_off) m_tready <= 0;
    else m_tready <= calm || ($urandom_range(99) >= 35);
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return 64'h0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return 64'hffff_ffff_8000_0000;
      5: return 64'h7fff_ffff;
      6: return 64'($urandom_range(70));
      7: return {32'($urandom), 32'($urandom)} >> $urandom_range(63);
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Leaves tvalid high after the accepting edge; the caller drops it or
  // offers the next request at the same falling edge.
  task automatic send_request(logic [3:0] act, logic [1:0] k,
                              logic [63:0] a, logic [63:0] b);
    s_tdata  <= {4'b0000, b, a, act};
    s_tuser  <= k;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_idle_gaps();
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        s_tvalid <= 0;
        @(negedge clk);
      end
    end
  endtask

  initial begin
    calm = 0;
    hold_off = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed corners: every action on a random kind, boundary operands.
    for (int act = 0; act < 14; act++)
      send_request(4'(act), 2'($urandom_range(3)), 64'h8000_0000_0000_0000, '1);
    send_request(ACT_DIV, 2'd0, 64'hffff_ffff_8000_0000, '1);
    send_request(ACT_MOD, 2'd2, 64'h8000_0000_0000_0000, '1);
    send_request(ACT_DIV, 2'd1, 64'h5, 64'h0);
    send_request(ACT_ADD, 2'd0, 64'h7fff_ffff, 64'h1);
    send_request(ACT_MUL, 2'd2, 64'h4000_0000_0000_0000, 64'h2);
    send_request(ACT_SHL, 2'd0, 64'h1, 64'd31);
    send_request(ACT_SHL, 2'd2, 64'h1, 64'd62);
    send_request(ACT_SHR, 2'd0, 64'hffff_ffff_ffff_fff0, 64'd4);
    send_request(ACT_SHR, 2'd3, 64'h1, 64'd64);
    send_request(ACT_NEG, 2'd0, 64'hffff_ffff_8000_0000, 64'h0);
    send_request(4'd15, 2'd3, '1, '1);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      calm = (i >= 400 && i < 600);
      if (i == 800) begin
        // Long receiver hold-off while the sender keeps offering requests.
        fork
          begin
            hold_off = 1;
            repeat (200) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      if (i == 1200) begin
        s_tvalid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      send_idle_gaps();
      send_request(4'($urandom_range(15)), 2'($urandom_range(3)),
                   pick_operand(), pick_operand());
    end

    calm = 0;
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cia_pkg.sv
hw/rtl/cia_front.sv
hw/rtl/cia_queue.sv
hw/rtl/cia_back.sv
hw/rtl/checked_integer_alu.sv
tb/alu_result_checker.sv
tb/tb_checked_integer_alu.sv
